// File: src/agwu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package agwu_pkg;

    localparam int TABLE_BITS_DEFAULT = 16;
    localparam logic [31:0] MULT_RESET = 32'd27942141;
    localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] first_index;
        logic signed [31:0] first_value;
        logic [31:0] second_index;
        logic signed [31:0] second_value;
        logic signed [31:0] step_size;
        logic [30:0] gradient_scale;
    } in_item_t;

    typedef struct packed {
        logic [15:0] entry_address;
        logic signed [31:0] new_weight;
        logic        skipped;
    } out_item_t;

    // Unsigned Q16.16 product of magnitudes, truncated.
    function automatic logic [47:0] qmul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        begin
            p = {32'd0, a} * {32'd0, b};
            qmul32 = p[63:16];
        end
    endfunction

endpackage
`default_nettype wire

// File: src/agwu_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Computes floor(sqrt(floor(2^48 / acc))) for acc > 0. A restoring divider
// produces the quotient one bit per cycle, then a digit-by-digit square
// root produces one result bit per cycle.
module agwu_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] acc,
    output logic             done,
    output logic [24:0]      root
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [48:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [49:0] sq_rem_reg, sq_rem_next;
    logic [24:0] res_reg, res_next;
    logic        done_reg, done_next;

    logic [33:0] rem_sh;
    logic [49:0] sq_try;
    logic [49:0] sq_sh;
    logic [49:0] quo_ext;

    // The quotient has an odd number of bits; a zero on top makes whole pairs.
    assign quo_ext = {1'b0, quo_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        sq_rem_next = sq_rem_reg;
        res_next = res_reg;
        done_next = 1'b0;
        rem_sh = '0;
        sq_sh = '0;
        sq_try = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIV;
                    cnt_next = 6'd48;
                    quo_next = 49'd1 << 48;
                    rem_next = '0;
                    den_next = acc;
                end
            end
            S_DIV:
            begin
                // Dividend bits shifted out of quo_reg from the top.
                rem_sh = {rem_reg, quo_reg[48]};
                if (rem_sh >= {2'b00, den_reg})
                begin
                    rem_next = 33'(rem_sh - {2'b00, den_reg});
                    quo_next = {quo_reg[47:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[32:0];
                    quo_next = {quo_reg[47:0], 1'b0};
                end
                cnt_next = 6'(cnt_reg - 6'd1);
                if (cnt_reg == 6'd0)
                begin
                    state_next = S_SQRT;
                    cnt_next = 6'd24;
                    sq_rem_next = '0;
                    res_next = '0;
                end
            end
            S_SQRT:
            begin
                // Bit pairs of the quotient are taken from the top down.
                sq_sh = {sq_rem_reg[47:0], quo_ext[{cnt_reg[4:0], 1'b0} +: 2]};
                sq_try = {23'd0, res_reg, 2'b01};
                if (sq_sh >= sq_try)
                begin
                    sq_rem_next = sq_sh - sq_try;
                    res_next = {res_reg[23:0], 1'b1};
                end
                else
                begin
                    sq_rem_next = sq_sh;
                    res_next = {res_reg[23:0], 1'b0};
                end
                cnt_next = 6'(cnt_reg - 6'd1);
                if (cnt_reg == 6'd0)
                begin
                    state_next = S_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        sq_rem_reg <= sq_rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;

    a_done_from_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_SQRT) else $error("done without root step");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DIV || state_reg == S_SQRT))
        else $error("divider left early");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> den_reg != 32'd0) else $error("zero divisor");
endmodule
`default_nettype wire

// File: src/adagrad_hashed_weight_update.sv
// From an accepted start to the done strobe, a full update runs through all its states; it ends
// early when step_size is zero or when the accumulator stays zero. One transaction at a time.
// The bit-serial divider and square root take most of the time; a new start is taken in the
// cycle done is high. The receiver cannot stall: done is high for one cycle, and the result
// holds until the next transaction overwrites it. Reset: the multiplier returns to its default,
// then busy stays high while every entry of both tables is cleared.
`timescale 1ns / 1ps
`default_nettype none
module adagrad_hashed_weight_update #(
    parameter int TABLE_BITS = agwu_pkg::TABLE_BITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire agwu_pkg::in_item_t in_item,
    output logic                   done,
    output agwu_pkg::out_item_t    out_item,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_V2    = 4'd3;
    localparam logic [3:0] S_INC   = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_T     = 4'd7;
    localparam logic [3:0] S_D     = 4'd8;
    localparam logic [3:0] S_W     = 4'd9;
    localparam logic [3:0] S_PAIR  = 4'd10;
    localparam logic [3:0] S_SUM   = 4'd11;
    localparam logic [3:0] S_DSUM  = 4'd12;

    logic [31:0] wm [2**TABLE_BITS];
    logic [31:0] a_mem [2**TABLE_BITS];
    logic [31:0] w_rd_reg, a_rd_reg;

    logic [3:0]  state_reg, state_next;
    logic [31:0] mult_reg;
    logic [TABLE_BITS-1:0] clr_reg;
    logic [TABLE_BITS-1:0] addr_reg;
    agwu_pkg::in_item_t item_reg;
    logic [31:0] v_mag_reg;
    logic        v_neg_reg;
    logic [47:0] prod_reg;
    logic [54:0] pp_hi_reg, pp_lo_reg;
    logic [31:0] acc_reg;
    logic signed [31:0] w_reg;
    logic        done_reg, done_next;
    logic        skip_reg;
    logic        root_start;
    logic        root_done;
    logic [24:0] root;

    logic        we;
    logic [TABLE_BITS-1:0] wa;
    logic [31:0] wd_w, wd_a;
    logic        we_a;

    logic [31:0] hash;
    logic [31:0] x1m, x2m;
    logic [31:0] step_mag;
    logic [47:0] p;
    logic [78:0] inc_full;
    logic [30:0] inc_val;
    logic [31:0] acc_sum;
    logic [56:0] t_full;
    logic [74:0] dm_full;
    logic signed [34:0] wsum;
    logic signed [31:0] w_new;

    assign hash = item_reg.kind ? 32'(mult_reg * item_reg.first_index + item_reg.second_index)
                                : item_reg.first_index;
    assign x1m = item_reg.first_value[31] ? 32'(-item_reg.first_value) : item_reg.first_value;
    assign x2m = item_reg.second_value[31] ? 32'(-item_reg.second_value)
                                           : item_reg.second_value;
    assign step_mag = item_reg.step_size[31] ? 32'(-item_reg.step_size) : item_reg.step_size;
    assign p = agwu_pkg::qmul32(x1m, x2m);

    // The wide products are split in two halves and summed in the following cycle.
    assign inc_full = {pp_hi_reg, 24'd0} + {24'd0, pp_lo_reg};
    assign inc_val = (inc_full[78:47] != 32'd0) ? agwu_pkg::ACC_MAX[30:0] : inc_full[46:16];
    assign acc_sum = {1'b0, a_rd_reg[30:0]} + {1'b0, inc_val};
    assign t_full = 57'(v_mag_reg) * 57'(root);
    assign dm_full = {pp_hi_reg, 20'd0} + {20'd0, pp_lo_reg};

    assign wsum = (item_reg.step_size[31] ^ v_neg_reg)
                  ? 35'(w_reg) - $signed({1'b0, prod_reg[33:0]})
                  : 35'(w_reg) + $signed({1'b0, prod_reg[33:0]});

    always_comb
    begin
        if (wsum > 35'sh7FFF_FFFF)
            w_new = 32'sh7FFF_FFFF;
        else if (wsum < -35'sh8000_0000)
            w_new = 32'sh8000_0000;
        else
            w_new = wsum[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
                if (clr_reg == '1)
                    state_next = S_IDLE;
            S_IDLE:
                if (start)
                    state_next = S_PAIR;
            S_PAIR: state_next = S_READ;
            S_READ: state_next = S_V2;
            S_V2:
            begin
                if (item_reg.step_size == 32'sd0)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_INC;
            end
            S_INC: state_next = S_SUM;
            S_SUM: state_next = S_ACC;
            S_ACC:
            begin
                if (acc_reg == 32'd0)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_ROOT;
            end
            S_ROOT:
                if (root_done)
                    state_next = S_T;
            S_T: state_next = S_D;
            S_D: state_next = S_DSUM;
            S_DSUM: state_next = S_W;
            S_W:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            mult_reg <= agwu_pkg::MULT_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mult_reg <= cfg_wdata;
            if (state_reg == S_CLEAR)
                clr_reg <= TABLE_BITS'(clr_reg + 1'b1);
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    assign root_start = (state_reg == S_ACC) && (acc_reg != 32'd0);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            item_reg <= in_item;
        unique case (state_reg)
            S_PAIR:
            begin
                addr_reg <= hash[TABLE_BITS-1:0];
                if (!item_reg.kind)
                begin
                    v_mag_reg <= x1m;
                    v_neg_reg <= item_reg.first_value[31];
                end
                else
                begin
                    v_neg_reg <= (item_reg.first_value[31] ^ item_reg.second_value[31])
                                 && (p != 48'd0);
                    if (item_reg.first_value[31] ^ item_reg.second_value[31])
                        v_mag_reg <= (p > 48'h8000_0000) ? 32'h8000_0000 : p[31:0];
                    else
                        v_mag_reg <= (p > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
                end
            end
            S_V2:
            begin
                w_reg <= w_rd_reg;
                skip_reg <= 1'b1;
                prod_reg <= agwu_pkg::qmul32(v_mag_reg, v_mag_reg);
            end
            S_INC:
            begin
                pp_hi_reg <= 55'(item_reg.gradient_scale) * 55'(prod_reg[47:24]);
                pp_lo_reg <= 55'(item_reg.gradient_scale) * 55'(prod_reg[23:0]);
            end
            S_SUM:
                acc_reg <= acc_sum[31] ? agwu_pkg::ACC_MAX : acc_sum;
            S_T:
                prod_reg <= {7'd0, t_full[56:16]};
            S_D:
            begin
                pp_hi_reg <= 55'(step_mag) * 55'(prod_reg[39:20]);
                pp_lo_reg <= 55'(step_mag) * 55'(prod_reg[19:0]);
            end
            S_DSUM:
                prod_reg <= (dm_full[74:16] > 59'h2_0000_0000) ? 48'h2_0000_0000
                                                              : {14'd0, dm_full[49:16]};
            S_W:
            begin
                w_reg <= w_new;
                skip_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    // One write port each; reads registered.
    always_comb
    begin
        we = 1'b0;
        we_a = 1'b0;
        wa = addr_reg;
        wd_w = w_new;
        wd_a = acc_reg;
        if (state_reg == S_CLEAR)
        begin
            we = 1'b1;
            we_a = 1'b1;
            wa = clr_reg;
            wd_w = '0;
            wd_a = '0;
        end
        else if (state_reg == S_ACC)
            we_a = 1'b1;
        else if (state_reg == S_W)
            we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we) wm[wa] <= wd_w;
        if (we_a) a_mem[wa] <= wd_a;
        w_rd_reg <= wm[addr_reg];
        a_rd_reg <= a_mem[addr_reg];
    end

    agwu_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(root_start),
        .acc(acc_reg), .done(root_done), .root(root)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign out_item.entry_address = 16'(addr_reg);
    assign out_item.new_weight = w_reg;
    assign out_item.skipped = skip_reg;

    a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy) else $error("accepted during clear");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("result while busy");
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> !acc_reg[31]) else $error("accumulator overflow");
endmodule
`default_nettype wire
